>>> src/cmli_pkg.sv
`default_nettype none

package cmli_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_COLORS_DEF   = 256;
    localparam int CHANNEL_BITS_DEF = 16;

    // Number of entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Lookup values are unsigned Q1.16.
    localparam int FRAC_BITS = 16;
    localparam int VALUE_BITS = 17;
    localparam logic [VALUE_BITS-1:0] ONE_Q = 17'h10000;

    // Width of the configuration register.
    localparam int COUNT_BITS = 9;

    // Width of a result channel.
    localparam int OUT_CHAN_BITS = 16;

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Filter modes.
    localparam logic FILTER_NEAREST = 1'b0;
    localparam logic FILTER_LINEAR  = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // One input item.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  entry_index;
        logic [15:0] entry_red;
        logic [15:0] entry_green;
        logic [15:0] entry_blue;
        logic [16:0] sample_value;
        logic        filter_mode;
    } in_t;

    // One result item.
    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic        status;
    } out_t;

    // Classification of a queued item, decided by the front part.
    typedef struct packed {
        logic is_write;  // palette write, no result
        logic is_err;    // lookup value above one
        logic pick_lo;   // result is the lower entry as is
        logic pick_hi;   // result is the upper entry as is
    } ctrl_t;

endpackage

`default_nettype wire

>>> src/colormap_lookup_interpolate.sv
`default_nettype none

// Colormap engine: write items load RGB palette entries, lookup items map a Q1.16 value
// in [0,1] to a nearest or linearly blended palette color, with status 1 and black for
// values above 1.0. One item is accepted per cycle unless in_stall is high, and one
// result leaves per cycle unless out_stall holds it. A lookup passes, in order, the
// front register, where the value is scaled by the entry count less one, the queue,
// the registered two-port palette read, the weighting multiplier registers and the
// output register. Writes give no result and take effect in order with lookups, since
// both pass through the same queue to the palette port. A four-entry queue between the
// scaling front and the palette back lets an output stall be absorbed without stalling
// the input at once. The entry count is set through the configuration port (values of
// zero act as one, values above MAX_COLORS as MAX_COLORS); the user must change it
// only while no item is in flight, which the block itself does not enforce. Palette
// entries start undefined and must be written before a lookup touches them.
module colormap_lookup_interpolate #(
    parameter int MAX_COLORS   = cmli_pkg::MAX_COLORS_DEF,
    parameter int CHANNEL_BITS = cmli_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire cmli_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output cmli_pkg::out_t                        out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cmli_pkg::COUNT_BITS-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_COLORS);

    logic                            push;
    logic                            q_full;
    logic                            q_not_empty;
    logic                            pop;
    cmli_pkg::ctrl_t                 push_ctrl;
    logic [AW-1:0]                   push_addr;
    logic [3*CHANNEL_BITS-1:0]       push_data;
    logic [cmli_pkg::FRAC_BITS-1:0]  push_frac;
    cmli_pkg::ctrl_t                 head_ctrl;
    logic [AW-1:0]                   head_addr;
    logic [3*CHANNEL_BITS-1:0]       head_data;
    logic [cmli_pkg::FRAC_BITS-1:0]  head_frac;

    // Front part: accepts, scales and classifies items.
    cmli_front #(
        .MAX_COLORS   (MAX_COLORS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_addr (push_addr),
        .push_data (push_data),
        .push_frac (push_frac)
    );

    // Queue between the two parts.
    cmli_queue #(
        .MAX_COLORS   (MAX_COLORS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_addr (push_addr),
        .push_data (push_data),
        .push_frac (push_frac),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head_ctrl (head_ctrl),
        .head_addr (head_addr),
        .head_data (head_data),
        .head_frac (head_frac)
    );

    // Back part: palette access, blending and result register.
    cmli_back #(
        .MAX_COLORS   (MAX_COLORS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .head_ctrl   (head_ctrl),
        .head_addr   (head_addr),
        .head_data   (head_data),
        .head_frac   (head_frac),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

>>> src/cmli_ram.sv
`default_nettype none

module cmli_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Two registered read ports; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> src/cmli_front.sv
`default_nettype none

module cmli_front #(
    parameter int MAX_COLORS   = cmli_pkg::MAX_COLORS_DEF,
    parameter int CHANNEL_BITS = cmli_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire cmli_pkg::in_t                        in_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cmli_pkg::COUNT_BITS-1:0]      cfg_data,
    input  wire logic                                 q_full,
    output logic                                      push,
    output cmli_pkg::ctrl_t                           push_ctrl,
    output logic [$clog2(MAX_COLORS)-1:0]             push_addr,
    output logic [3*CHANNEL_BITS-1:0]                 push_data,
    output logic [cmli_pkg::FRAC_BITS-1:0]            push_frac
);

    localparam int AW = $clog2(MAX_COLORS);
    localparam int NW = AW + cmli_pkg::COUNT_BITS + 1;
    localparam int PW = cmli_pkg::VALUE_BITS + AW;
    localparam int IW = AW + 8;
    localparam int EW = (CHANNEL_BITS > 16) ? CHANNEL_BITS : 16;

    logic [AW-1:0]                   scale_reg;
    logic [AW-1:0]                   scale_next;
    logic                            f_valid_reg;
    logic                            f_valid_next;
    cmli_pkg::ctrl_t                 f_ctrl_reg;
    cmli_pkg::ctrl_t                 f_ctrl_next;
    logic [AW-1:0]                   f_addr_reg;
    logic [AW-1:0]                   f_addr_next;
    logic [3*CHANNEL_BITS-1:0]       f_data_reg;
    logic [3*CHANNEL_BITS-1:0]       f_data_next;
    logic [cmli_pkg::FRAC_BITS-1:0]  f_frac_reg;
    logic [cmli_pkg::FRAC_BITS-1:0]  f_frac_next;

    logic [NW-1:0]                   count_ext;
    logic [IW-1:0]                   idx_ext;
    logic                            is_write;
    logic                            wr_in_range;
    logic                            drop;
    logic                            load;
    logic [PW-1:0]                   scaled;
    logic [AW-1:0]                   icol;
    logic [cmli_pkg::FRAC_BITS-1:0]  frac;
    logic [EW-1:0]                   red_ext;
    logic [EW-1:0]                   green_ext;
    logic [EW-1:0]                   blue_ext;

    // The register write always completes at once.
    assign cfg_ready = 1'b1;

    // Scale factor is the clamped entry count minus one.
    always_comb
    begin
        count_ext = NW'(cfg_data);
        scale_next = scale_reg;
        if (cfg_valid)
        begin
            if (count_ext == '0)
            begin
                scale_next = '0;
            end
            else if (count_ext > NW'(MAX_COLORS))
            begin
                scale_next = AW'(MAX_COLORS - 1);
            end
            else
            begin
                scale_next = AW'(count_ext - NW'(1));
            end
        end
    end

    // Split the scaled value into entry index and fraction.
    assign scaled = PW'(in_data.sample_value) * PW'(scale_reg);
    assign icol   = scaled[cmli_pkg::FRAC_BITS +: AW];
    assign frac   = scaled[cmli_pkg::FRAC_BITS-1:0];

    // Writes beyond the store are dropped here and never queued.
    assign is_write    = (in_data.cmd == cmli_pkg::CMD_WRITE);
    assign idx_ext     = IW'(in_data.entry_index);
    assign wr_in_range = (idx_ext < IW'(MAX_COLORS));
    assign drop        = is_write && !wr_in_range;

    // Channels are kept to the stored channel width.
    assign red_ext   = EW'(in_data.entry_red);
    assign green_ext = EW'(in_data.entry_green);
    assign blue_ext  = EW'(in_data.entry_blue);

    // Handshake with the queue.
    assign in_stall = f_valid_reg && q_full;
    assign push     = f_valid_reg && !q_full;
    assign load     = !in_stall;

    // Classify the incoming item.
    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_ctrl_next  = f_ctrl_reg;
        f_addr_next  = f_addr_reg;
        f_data_next  = f_data_reg;
        f_frac_next  = f_frac_reg;
        if (load)
        begin
            f_valid_next = in_valid && !drop;
        end
        if (load && in_valid)
        begin
            f_ctrl_next.is_write = is_write;
            f_ctrl_next.is_err   = !is_write && (in_data.sample_value > cmli_pkg::ONE_Q);
            if (in_data.filter_mode == cmli_pkg::FILTER_NEAREST)
            begin
                f_ctrl_next.pick_lo = !frac[cmli_pkg::FRAC_BITS-1];
                f_ctrl_next.pick_hi = frac[cmli_pkg::FRAC_BITS-1];
            end
            else
            begin
                f_ctrl_next.pick_lo = (frac == '0);
                f_ctrl_next.pick_hi = 1'b0;
            end
            f_addr_next = is_write ? idx_ext[AW-1:0] : icol;
            f_data_next = {red_ext[CHANNEL_BITS-1:0], green_ext[CHANNEL_BITS-1:0],
                           blue_ext[CHANNEL_BITS-1:0]};
            f_frac_next = frac;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= '0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            scale_reg   <= scale_next;
            f_valid_reg <= f_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        f_ctrl_reg <= f_ctrl_next;
        f_addr_reg <= f_addr_next;
        f_data_reg <= f_data_next;
        f_frac_reg <= f_frac_next;
    end

    assign push_ctrl = f_ctrl_reg;
    assign push_addr = f_addr_reg;
    assign push_data = f_data_reg;
    assign push_frac = f_frac_reg;

endmodule

`default_nettype wire

>>> src/cmli_queue.sv
`default_nettype none

module cmli_queue #(
    parameter int MAX_COLORS   = cmli_pkg::MAX_COLORS_DEF,
    parameter int CHANNEL_BITS = cmli_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire cmli_pkg::ctrl_t                      push_ctrl,
    input  wire logic [$clog2(MAX_COLORS)-1:0]        push_addr,
    input  wire logic [3*CHANNEL_BITS-1:0]            push_data,
    input  wire logic [cmli_pkg::FRAC_BITS-1:0]       push_frac,
    output logic                                      full,
    output logic                                      not_empty,
    input  wire logic                                 pop,
    output cmli_pkg::ctrl_t                           head_ctrl,
    output logic [$clog2(MAX_COLORS)-1:0]             head_addr,
    output logic [3*CHANNEL_BITS-1:0]                 head_data,
    output logic [cmli_pkg::FRAC_BITS-1:0]            head_frac
);

    localparam int DEPTH = cmli_pkg::QUEUE_DEPTH;
    localparam int PTW   = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(MAX_COLORS);

    cmli_pkg::ctrl_t                 ctrl_reg [DEPTH];
    logic [AW-1:0]                   addr_reg [DEPTH];
    logic [3*CHANNEL_BITS-1:0]       data_reg [DEPTH];
    logic [cmli_pkg::FRAC_BITS-1:0]  frac_reg [DEPTH];

    logic [PTW-1:0] wr_ptr_reg;
    logic [PTW-1:0] wr_ptr_next;
    logic [PTW-1:0] rd_ptr_reg;
    logic [PTW-1:0] rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_reg[wr_ptr_reg] <= push_ctrl;
            addr_reg[wr_ptr_reg] <= push_addr;
            data_reg[wr_ptr_reg] <= push_data;
            frac_reg[wr_ptr_reg] <= push_frac;
        end
    end

    assign head_ctrl = ctrl_reg[rd_ptr_reg];
    assign head_addr = addr_reg[rd_ptr_reg];
    assign head_data = data_reg[rd_ptr_reg];
    assign head_frac = frac_reg[rd_ptr_reg];

    // Occupancy never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    // A lone transfer in moves the occupancy up by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue occupancy did not follow a push");

    // A pop is only taken from a queue holding an entry.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

>>> src/cmli_back.sv
`default_nettype none

module cmli_back #(
    parameter int MAX_COLORS   = cmli_pkg::MAX_COLORS_DEF,
    parameter int CHANNEL_BITS = cmli_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_not_empty,
    output logic                                      pop,
    input  wire cmli_pkg::ctrl_t                      head_ctrl,
    input  wire logic [$clog2(MAX_COLORS)-1:0]        head_addr,
    input  wire logic [3*CHANNEL_BITS-1:0]            head_data,
    input  wire logic [cmli_pkg::FRAC_BITS-1:0]       head_frac,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output cmli_pkg::out_t                            out_data
);

    localparam int AW  = $clog2(MAX_COLORS);
    localparam int CB  = CHANNEL_BITS;
    localparam int MW  = CB + cmli_pkg::VALUE_BITS;
    localparam int SW  = MW + 1;
    localparam int EW  = (CB > 16) ? CB : 16;
    localparam int FB  = cmli_pkg::FRAC_BITS;
    localparam int VB  = cmli_pkg::VALUE_BITS;

    logic                 en;
    logic                 rd_en;
    logic [AW-1:0]        addr_hi;
    logic [3*CB-1:0]      rdata_lo;
    logic [3*CB-1:0]      rdata_hi;

    // Stage 1: palette read in flight.
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    cmli_pkg::ctrl_t      s1_ctrl_reg;
    cmli_pkg::ctrl_t      s1_ctrl_next;
    logic [FB-1:0]        s1_frac_reg;
    logic [FB-1:0]        s1_frac_next;

    // Stage 2: weighted channels.
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    cmli_pkg::ctrl_t      s2_ctrl_reg;
    cmli_pkg::ctrl_t      s2_ctrl_next;
    logic [3*CB-1:0]      s2_lo_reg;
    logic [3*CB-1:0]      s2_lo_next;
    logic [3*CB-1:0]      s2_hi_reg;
    logic [3*CB-1:0]      s2_hi_next;
    logic [3*MW-1:0]      s2_plo_reg;
    logic [3*MW-1:0]      s2_plo_next;
    logic [3*MW-1:0]      s2_phi_reg;
    logic [3*MW-1:0]      s2_phi_next;

    // Stage 3: result register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    cmli_pkg::out_t       out_data_reg;
    cmli_pkg::out_t       out_data_next;

    logic [VB-1:0]        w_hi;
    logic [VB-1:0]        w_lo;
    logic [SW-1:0]        sum  [3];
    logic [CB-1:0]        res  [3];
    logic [EW-1:0]        res_ext [3];

    // The whole back part moves while the result register can take a transfer.
    assign en    = !out_valid_reg || !out_stall;
    assign pop   = en && q_not_empty;
    assign rd_en = pop && !head_ctrl.is_write;
    assign addr_hi = head_addr + AW'(1);

    cmli_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_COLORS)
    ) u_palette (
        .clk     (clk),
        .we      (pop && head_ctrl.is_write),
        .waddr   (head_addr),
        .wdata   (head_data),
        .re      (rd_en),
        .raddr_a (head_addr),
        .raddr_b (addr_hi),
        .rdata_a (rdata_lo),
        .rdata_b (rdata_hi)
    );

    // Stage 1: only lookups go on; writes end at the palette.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_ctrl_next  = s1_ctrl_reg;
        s1_frac_next  = s1_frac_reg;
        if (en)
        begin
            s1_valid_next = rd_en;
            s1_ctrl_next  = head_ctrl;
            s1_frac_next  = head_frac;
        end
    end

    // Stage 2: weight both neighbors, one multiplier per channel and side.
    assign w_hi = VB'(s1_frac_reg);
    assign w_lo = cmli_pkg::ONE_Q - w_hi;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_ctrl_next  = s2_ctrl_reg;
        s2_lo_next    = s2_lo_reg;
        s2_hi_next    = s2_hi_reg;
        s2_plo_next   = s2_plo_reg;
        s2_phi_next   = s2_phi_reg;
        if (en)
        begin
            s2_valid_next = s1_valid_reg;
            s2_ctrl_next  = s1_ctrl_reg;
            s2_lo_next    = rdata_lo;
            s2_hi_next    = rdata_hi;
            for (int ch = 0; ch < 3; ch++)
            begin
                s2_plo_next[ch*MW +: MW] = MW'(rdata_lo[ch*CB +: CB]) * MW'(w_lo);
                s2_phi_next[ch*MW +: MW] = MW'(rdata_hi[ch*CB +: CB]) * MW'(w_hi);
            end
        end
    end

    // Stage 3: blend, pick or zero, then fit to the result channel width.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = SW'(s2_plo_reg[ch*MW +: MW]) + SW'(s2_phi_reg[ch*MW +: MW]);
            if (s2_ctrl_reg.is_err)
            begin
                res[ch] = '0;
            end
            else if (s2_ctrl_reg.pick_lo)
            begin
                res[ch] = s2_lo_reg[ch*CB +: CB];
            end
            else if (s2_ctrl_reg.pick_hi)
            begin
                res[ch] = s2_hi_reg[ch*CB +: CB];
            end
            else
            begin
                res[ch] = sum[ch][FB +: CB];
            end
            res_ext[ch] = EW'(res[ch]);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (en)
        begin
            out_valid_next          = s2_valid_reg;
            out_data_next.out_red   = res_ext[2][cmli_pkg::OUT_CHAN_BITS-1:0];
            out_data_next.out_green = res_ext[1][cmli_pkg::OUT_CHAN_BITS-1:0];
            out_data_next.out_blue  = res_ext[0][cmli_pkg::OUT_CHAN_BITS-1:0];
            out_data_next.status    = s2_ctrl_reg.is_err ? cmli_pkg::STATUS_RANGE
                                                         : cmli_pkg::STATUS_OK;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_ctrl_reg  <= s1_ctrl_next;
        s1_frac_reg  <= s1_frac_next;
        s2_ctrl_reg  <= s2_ctrl_next;
        s2_lo_reg    <= s2_lo_next;
        s2_hi_reg    <= s2_hi_next;
        s2_plo_reg   <= s2_plo_next;
        s2_phi_reg   <= s2_phi_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An out-of-range result carries zero in every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status == cmli_pkg::STATUS_RANGE)) |->
        ((out_data_reg.out_red == '0) && (out_data_reg.out_green == '0) &&
         (out_data_reg.out_blue == '0)))
        else $error("out-of-range result with nonzero channels");

    // While the result is held, nothing leaves the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("queue popped while the result is held");

    // A held pipeline keeps its lookup in the read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (s1_valid_reg == $past(s1_valid_reg)))
        else $error("read stage moved during a hold");

endmodule

`default_nettype wire
